### design/b32e_pkg.sv
// Shared types, constants and lookup functions for the base32 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b32e_pkg;

   // Default depth of the job queue between front and back.
   localparam int DEF_QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_UPPER_A = 8'd65;  // 'A' for group values 0..25
   localparam logic [7:0] DIGIT_OFFSET = 8'd24;  // '2' - 26 for group values 26..31
   localparam logic [4:0] FIRST_DIGIT  = 5'd26;
   localparam logic [7:0] PAD_CHAR     = 8'd61;  // '='

   // One accepted byte, classified: its characters and how many to emit.
   typedef struct packed {
      logic [14:0] groups;   // up to three 5-bit groups, left aligned
      logic [1:0]  n_data;   // alphabet characters, 1..3
      logic [3:0]  n_total;  // alphabet characters plus pads, 1..8
      logic        fin;      // beat closes the message
   } job_type;

   function automatic logic [7:0] b32_char(input logic [4:0] idx);
      logic [7:0] ch;
      if (idx < FIRST_DIGIT) begin
         ch = CHAR_UPPER_A + {3'b000, idx};
      end else begin
         ch = DIGIT_OFFSET + {3'b000, idx};
      end
      return ch;
   endfunction

   // Pads after the final byte, by leftover bit count.
   function automatic logic [2:0] pad_count(input logic [2:0] rest);
      logic [2:0] pads;
      case (rest)
         3'd1:    pads = 3'd4;
         3'd2:    pads = 3'd1;
         3'd3:    pads = 3'd6;
         3'd4:    pads = 3'd3;
         default: pads = 3'd0;
      endcase
      return pads;
   endfunction

endpackage

`default_nettype wire

### design/b32e_front.sv
// Front end: takes bytes, carries leftover bits, builds one job per byte.
`timescale 1ns / 1ps
`default_nettype none

module b32e_front import b32e_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   input  wire logic       q_full,
   output logic            q_push,
   output job_type         q_job
);

   logic [3:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic [11:0] acc;
   logic [3:0]  total_bits;
   logic [14:0] aligned;
   logic        two_groups;
   logic [2:0]  rest;
   logic        flush;
   logic [1:0]  n_data;
   logic [2:0]  pads;
   logic [3:0]  rest_mask;

   always_comb begin
      acc        = {pend_bits_ff, req_data_byte};
      total_bits = {1'b0, pend_cnt_ff} + 4'd8;
      aligned    = {3'b000, acc} << (4'd15 - total_bits);
      two_groups = total_bits >= 4'd10;
      rest       = two_groups ? 3'(total_bits - 4'd10) : 3'(total_bits - 4'd5);
      flush      = req_final_byte && (rest != 3'd0);
      n_data     = (two_groups ? 2'd2 : 2'd1) + {1'b0, flush};
      pads       = req_final_byte ? pad_count(rest) : 3'd0;
      rest_mask  = 4'((5'd1 << rest) - 5'd1);

      q_push         = req_push && !q_full;
      q_job.groups   = aligned;
      q_job.n_data   = n_data;
      q_job.n_total  = {2'b00, n_data} + {1'b0, pads};
      q_job.fin      = req_final_byte;

      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      if (q_push) begin
         if (req_final_byte) begin
            pend_bits_in = 4'd0;
            pend_cnt_in  = 3'd0;
         end else begin
            pend_bits_in = acc[3:0] & rest_mask;
            pend_cnt_in  = rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= 4'd0;
         pend_cnt_ff  <= 3'd0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_pend_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= 3'd4)
      else $error("leftover bit count out of range");
`endif

endmodule

`default_nettype wire

### design/b32e_queue.sv
// Small job queue between front and back.
`timescale 1ns / 1ps
`default_nettype none

module b32e_queue import b32e_pkg::*; #(
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   output logic         full,
   input  wire logic    rd_en,
   output logic         rd_valid,
   output job_type      rd_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full     = count_ff == CNT_W'(DEPTH);
      rd_valid = count_ff != '0;
      rd_job   = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy out of range");
`endif

endmodule

`default_nettype wire

### design/b32e_back.sv
// Back end: walks each job one character per cycle, while the result register is free, into that register.
`timescale 1ns / 1ps
`default_nettype none

module b32e_back import b32e_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire job_type q_job,
   output logic      q_pop,
   output logic       rsp_empty,
   input  wire logic  rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   job_type    cur_ff, cur_in;
   logic       active_ff, active_in;
   logic [3:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       last_ff, last_in;

   logic       out_ready;
   logic       emit;
   logic       last_step;
   logic       load;
   logic [4:0] idx;
   logic [7:0] ch;

   always_comb begin
      out_ready = !out_valid_ff || rsp_pop;
      emit      = active_ff && out_ready;
      last_step = step_ff == (cur_ff.n_total - 4'd1);
      load      = q_valid && (!active_ff || (emit && last_step));
      q_pop     = load;

      case (step_ff[1:0])
         2'd0:    idx = cur_ff.groups[14:10];
         2'd1:    idx = cur_ff.groups[9:5];
         2'd2:    idx = cur_ff.groups[4:0];
         default: idx = 5'd0;
      endcase
      ch = (step_ff < {2'b00, cur_ff.n_data}) ? b32_char(idx) : PAD_CHAR;

      cur_in    = load ? q_job : cur_ff;
      active_in = active_ff;
      step_in   = step_ff;
      if (load) begin
         active_in = 1'b1;
         step_in   = 4'd0;
      end else if (emit) begin
         active_in = !last_step;
         step_in   = step_ff + 4'd1;
      end

      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         last_in      = cur_ff.fin && last_step;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end

      rsp_empty     = !out_valid_ff;
      rsp_out_char  = out_char_ff;
      rsp_last_char = last_ff;
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      last_ff     <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (step_ff < cur_ff.n_total))
      else $error("character step past end of job");

   a_final_marks_last: assert property (@(posedge clock) disable iff (reset)
      (emit && last_step && cur_ff.fin) |=> (rsp_last_char && !rsp_empty))
      else $error("final character of message not flagged");
`endif

endmodule

`default_nettype wire

### design/base32_stream_encoder.sv
// Top level of the streaming base32 encoder: front end, job queue, back end.
// A byte passes the job queue and the back's job register on its way to the rsp_ register.
// Throughput: one character per cycle while rsp_pop keeps the result register free; a byte
// yields 1 or 2 characters, up to 8 on a final byte with pads; about 1.6 on average.
// The figure is set by the single character register at the result side.
// Reset (synchronous, active high) clears leftover bits, the job queue and the output.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_encoder import b32e_pkg::*; #(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH  // jobs buffered between front and back
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input beats: raw message bytes
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_final_byte,
   // result beats: encoded characters, oldest first
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_out_char,
   output logic            rsp_last_char
);

   // Front to queue
   logic    q_push;
   job_type q_wr_job;
   logic    q_full;
   // Queue to back
   logic    q_valid;
   logic    q_pop;
   job_type q_rd_job;

   // The input side stalls only when the job queue is full; one byte makes one job.
   assign req_full = q_full;

   // Front: merges carried bits with the byte, splits into 5-bit groups, counts pads.
   b32e_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (q_wr_job)
   );

   // Queue: lets bytes keep arriving while a long final job drains.
   b32e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_job   (q_wr_job),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_job   (q_rd_job)
   );

   // Back: maps groups to ASCII, appends '=' pads, flags the message end.
   // It picks up the next job in the cycle it emits the last character of the
   // current one, so characters leave without gaps while jobs wait in the queue.
   b32e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_job         (q_rd_job),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire
